/* src/six_wheel_steering_inverse_kinematics_assert.svh */
// Assertion macros for the six wheel steering block checkers.
// Include this file where concurrent checks are written.
`ifndef SIX_WHEEL_STEERING_INVERSE_KINEMATICS_ASSERT_SVH
`define SIX_WHEEL_STEERING_INVERSE_KINEMATICS_ASSERT_SVH

// Same-cycle implication, reported by $error
`define SWIK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reported by $error
`define SWIK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/swik_pkg.sv */
// Shared types, constants and per-stage arithmetic for the six wheel
// steering inverse kinematics block. No dependencies.
package swik_pkg;

   localparam int FRAC_BITS    = 10;
   localparam int IN_W         = 16;
   localparam int CFG_W        = 13;
   localparam int ANG_W        = 16;
   localparam int SPD_W        = 19;
   localparam int NUM_WHEELS   = 6;

   // Yaw times a distance: 16 bit signed by 13 bit unsigned
   localparam int PROD_W       = IN_W + CFG_W + 1;
   // Wheel component magnitude bits and signed width
   localparam int MAG_W        = ((IN_W - 1 + FRAC_BITS > IN_W - 1 + CFG_W) ?
                                  (IN_W - 1 + FRAC_BITS) : (IN_W - 1 + CFG_W)) + 1;
   localparam int UW           = MAG_W + 1;
   localparam int SQ_W         = 2 * MAG_W;
   localparam int N_W          = 2 * MAG_W + 1;
   localparam int RT_STEPS     = MAG_W + 1;

   // Angle path
   localparam int CORDIC_STEPS = 20;
   localparam int NORM_EXP     = 40;
   localparam int CW           = 44;
   localparam int ZW           = 22;
   localparam int SH_W         = 6;
   localparam int Z_MAX        = 1 << 19;
   localparam int Z_RND        = 16;
   localparam int Z_SHIFT      = 5;
   localparam int QUARTER      = 16384;
   localparam int HALF_TURN    = 32768;
   localparam int SPEED_MAX    = (1 << SPD_W) - 1;
   localparam int SPEED_HALF   = 1 << (FRAC_BITS - 1);

   localparam int unsigned ATAN_TAB [CORDIC_STEPS] = '{
      262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608, 1304, 652,
      326, 163, 81, 41, 20, 10, 5, 3, 1, 1
   };

   // Pipeline stage numbers
   localparam int ST_IN    = 0;
   localparam int ST_PROD  = 1;
   localparam int ST_COMP  = 2;
   localparam int ST_SQ    = 3;
   localparam int ST_PREP  = 4;
   localparam int ST_OUT   = ST_PREP + RT_STEPS + 1;
   localparam int NSTG     = ST_OUT + 1;

   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] HALF_TRACK_RST  = 13'd512;
   localparam logic [CFG_W-1:0] FRONT_DIST_RST  = 13'd1024;
   localparam logic [CFG_W-1:0] REAR_DIST_RST   = 13'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_TRACK = 2'd0,
      CSR_FRONT_DIST = 2'd1,
      CSR_REAR_DIST  = 2'd2
   } swik_csr_type;

   typedef struct packed {
      logic signed [IN_W-1:0] lin_x;
      logic signed [IN_W-1:0] lin_y;
      logic signed [IN_W-1:0] yaw_rate;
   } swik_req_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] front_right_angle;
      logic        [SPD_W-1:0] front_right_speed;
      logic signed [ANG_W-1:0] front_left_angle;
      logic        [SPD_W-1:0] front_left_speed;
      logic signed [ANG_W-1:0] mid_right_angle;
      logic        [SPD_W-1:0] mid_right_speed;
      logic signed [ANG_W-1:0] mid_left_angle;
      logic        [SPD_W-1:0] mid_left_speed;
      logic signed [ANG_W-1:0] rear_right_angle;
      logic        [SPD_W-1:0] rear_right_speed;
      logic signed [ANG_W-1:0] rear_left_angle;
      logic        [SPD_W-1:0] rear_left_speed;
   } swik_rsp_type;

   // One wheel in flight: square root remainder/root and CORDIC vector
   typedef struct packed {
      logic        [N_W-1:0] rem;
      logic        [N_W-1:0] root;
      logic signed [CW-1:0]  cx;
      logic signed [CW-1:0]  cy;
      logic signed [ZW-1:0]  cz;
      logic                  neg_x;
      logic                  neg_y;
      logic                  x_zero;
      logic                  y_zero;
   } swik_wheel_type;

   typedef struct packed {
      logic [ANG_W-1:0] angle;
      logic [SPD_W-1:0] speed;
   } swik_result_type;

   // One root digit, and one CORDIC rotation while steps remain
   function automatic swik_wheel_type wheel_step(input swik_wheel_type w,
                                                 input int unsigned s);
      swik_wheel_type        r;
      logic [N_W-1:0]        bitv;
      logic [N_W:0]          trial;
      logic signed [CW-1:0]  dx;
      logic signed [CW-1:0]  dy;
      r     = w;
      bitv  = N_W'(1) << (2 * (RT_STEPS - 1 - s));
      trial = {1'b0, w.root} + {1'b0, bitv};
      if ({1'b0, w.rem} >= trial) begin
         r.rem  = w.rem - trial[N_W-1:0];
         r.root = (w.root >> 1) + bitv;
      end else begin
         r.root = w.root >> 1;
      end
      if (s < CORDIC_STEPS) begin
         dx = w.cx >>> s;
         dy = w.cy >>> s;
         if (!w.cy[CW-1]) begin
            r.cx = w.cx + dy;
            r.cy = w.cy - dx;
            r.cz = w.cz + ZW'(ATAN_TAB[s]);
         end else begin
            r.cx = w.cx - dy;
            r.cy = w.cy + dx;
            r.cz = w.cz - ZW'(ATAN_TAB[s]);
         end
      end
      return r;
   endfunction

   // Clamp and round the angle, reflect by quadrant, round and saturate speed
   function automatic swik_result_type wheel_finish(input swik_wheel_type w);
      swik_result_type   r;
      logic [ZW-1:0]     zc;
      logic [ZW-1:0]     zr;
      logic [ANG_W+1:0]  a;
      logic [ANG_W+1:0]  t;
      logic [N_W:0]      sp;
      if (w.cz[ZW-1]) begin
         zc = '0;
      end else if ($unsigned(w.cz) > ZW'(Z_MAX)) begin
         zc = ZW'(Z_MAX);
      end else begin
         zc = $unsigned(w.cz);
      end
      zr = (zc + ZW'(Z_RND)) >> Z_SHIFT;
      if (w.y_zero) begin
         a = '0;
      end else if (w.x_zero) begin
         a = (ANG_W+2)'(QUARTER);
      end else begin
         a = (ANG_W+2)'(zr);
      end
      t = w.neg_x ? ((ANG_W+2)'(HALF_TURN) - a) : a;
      t = w.neg_y ? ((ANG_W+2)'(0) - t) : t;
      r.angle = t[ANG_W-1:0];
      sp = ({1'b0, w.root} + (N_W+1)'(SPEED_HALF)) >> FRAC_BITS;
      if (sp > (N_W+1)'(SPEED_MAX)) begin
         r.speed = SPD_W'(SPEED_MAX);
      end else begin
         r.speed = sp[SPD_W-1:0];
      end
      return r;
   endfunction

endpackage

/* src/six_wheel_steering_inverse_kinematics.sv */
// Six wheel steering inverse kinematics, pipelined top level.
// Throughput: one request per cycle unless rsp_stall holds the pipeline; the root
// digit chain (one digit per stage, 30 stages) sets the depth, CORDIC runs
// beside it in 20 stages.
// Reset (synchronous): clears all stage valids, loads register defaults.
// Depends on swik_pkg.
module six_wheel_steering_inverse_kinematics (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  swik_pkg::swik_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output swik_pkg::swik_rsp_type              rsp_payload,
   input  logic                                csr_we,
   input  logic [swik_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swik_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int NW = swik_pkg::NUM_WHEELS;

   // Configuration registers
   logic [swik_pkg::CFG_W-1:0] half_track_ff;
   logic [swik_pkg::CFG_W-1:0] front_dist_ff;
   logic [swik_pkg::CFG_W-1:0] rear_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_track_ff <= swik_pkg::HALF_TRACK_RST;
         front_dist_ff <= swik_pkg::FRONT_DIST_RST;
         rear_dist_ff  <= swik_pkg::REAR_DIST_RST;
      end else if (csr_we) begin
         unique case (swik_pkg::swik_csr_type'(csr_index))
            swik_pkg::CSR_HALF_TRACK: half_track_ff <= csr_wdata;
            swik_pkg::CSR_FRONT_DIST: front_dist_ff <= csr_wdata;
            swik_pkg::CSR_REAR_DIST:  rear_dist_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage advance: a stage loads when empty or when its successor loads
   logic [swik_pkg::NSTG-1:0] valid_ff;
   logic [swik_pkg::NSTG-1:0] adv;

   always_comb begin
      adv[swik_pkg::NSTG-1] = !valid_ff[swik_pkg::NSTG-1] || !rsp_stall;
      for (int k = swik_pkg::NSTG - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[swik_pkg::ST_IN];
   assign rsp_valid = valid_ff[swik_pkg::ST_OUT];

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < swik_pkg::NSTG; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Stage 0: hold the request
   swik_pkg::swik_req_type req_ff;

   always_ff @(posedge clock) begin
      if (adv[swik_pkg::ST_IN]) begin
         req_ff <= req_payload;
      end
   end

   // Stage 1: yaw rate times each distance
   logic signed [swik_pkg::IN_W-1:0]   lin_x_ff;
   logic signed [swik_pkg::IN_W-1:0]   lin_y_ff;
   logic signed [swik_pkg::PROD_W-1:0] prod_ht_ff;
   logic signed [swik_pkg::PROD_W-1:0] prod_fd_ff;
   logic signed [swik_pkg::PROD_W-1:0] prod_rd_ff;
   logic signed [swik_pkg::PROD_W-1:0] prod_ht_in;
   logic signed [swik_pkg::PROD_W-1:0] prod_fd_in;
   logic signed [swik_pkg::PROD_W-1:0] prod_rd_in;

   always_comb begin
      prod_ht_in = $signed(req_ff.yaw_rate) * $signed({1'b0, half_track_ff});
      prod_fd_in = $signed(req_ff.yaw_rate) * $signed({1'b0, front_dist_ff});
      prod_rd_in = -($signed(req_ff.yaw_rate) * $signed({1'b0, rear_dist_ff}));
   end

   always_ff @(posedge clock) begin
      if (adv[swik_pkg::ST_PROD]) begin
         lin_x_ff   <= req_ff.lin_x;
         lin_y_ff   <= req_ff.lin_y;
         prod_ht_ff <= prod_ht_in;
         prod_fd_ff <= prod_fd_in;
         prod_rd_ff <= prod_rd_in;
      end
   end

   logic signed [swik_pkg::UW-1:0] vx;
   logic signed [swik_pkg::UW-1:0] vy;

   assign vx = swik_pkg::UW'(lin_x_ff) <<< swik_pkg::FRAC_BITS;
   assign vy = swik_pkg::UW'(lin_y_ff) <<< swik_pkg::FRAC_BITS;

   // Per-wheel stages 2 to 4
   logic [swik_pkg::MAG_W-1:0] magx_ff [NW];
   logic [swik_pkg::MAG_W-1:0] magy_ff [NW];
   logic                       negx_ff [NW];
   logic                       negy_ff [NW];
   logic [swik_pkg::SQ_W-1:0]  sqx_ff  [NW];
   logic [swik_pkg::SQ_W-1:0]  sqy_ff  [NW];
   logic [swik_pkg::SH_W-1:0]  sh_ff   [NW];
   logic [swik_pkg::MAG_W-1:0] magx3_ff[NW];
   logic [swik_pkg::MAG_W-1:0] magy3_ff[NW];
   logic                       negx3_ff[NW];
   logic                       negy3_ff[NW];

   swik_pkg::swik_wheel_type chain_ff [swik_pkg::RT_STEPS+1][NW];

   for (genvar j = 0; j < NW; j++) begin : g_wheel
      logic signed [swik_pkg::UW-1:0]     ux;
      logic signed [swik_pkg::UW-1:0]     uy;
      logic signed [swik_pkg::PROD_W-1:0] px;
      logic [swik_pkg::SH_W-1:0]          sh_in;
      logic [swik_pkg::SH_W-1:0]          msb;
      logic [swik_pkg::MAG_W-1:0]         both;
      swik_pkg::swik_wheel_type           prep_in;

      // Lateral arm: front, middle (none) or rear
      if (j / 2 == 0) begin : g_front
         assign px = prod_fd_ff;
      end else if (j / 2 == 1) begin : g_mid
         assign px = '0;
      end else begin : g_rear
         assign px = prod_rd_ff;
      end

      // Right wheels sit at minus half track, left at plus
      if (j % 2 == 0) begin : g_right
         assign ux = vx + swik_pkg::UW'(prod_ht_ff);
      end else begin : g_left
         assign ux = vx - swik_pkg::UW'(prod_ht_ff);
      end
      assign uy = vy + swik_pkg::UW'(px);

      // Stage 2: split into sign and magnitude
      always_ff @(posedge clock) begin
         if (adv[swik_pkg::ST_COMP]) begin
            magx_ff[j] <= ux[swik_pkg::UW-1] ? swik_pkg::MAG_W'(-ux) : swik_pkg::MAG_W'(ux);
            magy_ff[j] <= uy[swik_pkg::UW-1] ? swik_pkg::MAG_W'(-uy) : swik_pkg::MAG_W'(uy);
            negx_ff[j] <= ux[swik_pkg::UW-1];
            negy_ff[j] <= uy[swik_pkg::UW-1];
         end
      end

      // Stage 3: squares and the normalizing shift
      always_comb begin
         both = magx_ff[j] | magy_ff[j];
         msb  = '0;
         for (int b = 0; b < swik_pkg::MAG_W; b++) begin
            if (both[b]) begin
               msb = swik_pkg::SH_W'(b);
            end
         end
         sh_in = swik_pkg::SH_W'(swik_pkg::NORM_EXP) - msb;
      end

      always_ff @(posedge clock) begin
         if (adv[swik_pkg::ST_SQ]) begin
            sqx_ff[j]   <= swik_pkg::SQ_W'(magx_ff[j]) * swik_pkg::SQ_W'(magx_ff[j]);
            sqy_ff[j]   <= swik_pkg::SQ_W'(magy_ff[j]) * swik_pkg::SQ_W'(magy_ff[j]);
            sh_ff[j]    <= sh_in;
            magx3_ff[j] <= magx_ff[j];
            magy3_ff[j] <= magy_ff[j];
            negx3_ff[j] <= negx_ff[j];
            negy3_ff[j] <= negy_ff[j];
         end
      end

      // Stage 4: sum of squares, normalized CORDIC start vector
      always_comb begin
         prep_in.rem    = swik_pkg::N_W'(sqx_ff[j]) + swik_pkg::N_W'(sqy_ff[j]);
         prep_in.root   = '0;
         prep_in.cx     = swik_pkg::CW'(magx3_ff[j]) << sh_ff[j];
         prep_in.cy     = swik_pkg::CW'(magy3_ff[j]) << sh_ff[j];
         prep_in.cz     = '0;
         prep_in.neg_x  = negx3_ff[j];
         prep_in.neg_y  = negy3_ff[j];
         prep_in.x_zero = (magx3_ff[j] == '0);
         prep_in.y_zero = (magy3_ff[j] == '0);
      end

      always_ff @(posedge clock) begin
         if (adv[swik_pkg::ST_PREP]) begin
            chain_ff[0][j] <= prep_in;
         end
      end

      // Root digit and CORDIC stages
      for (genvar s = 1; s <= swik_pkg::RT_STEPS; s++) begin : g_iter
         swik_pkg::swik_wheel_type step_in;

         assign step_in = swik_pkg::wheel_step(chain_ff[s-1][j], (s - 1));

         always_ff @(posedge clock) begin
            if (adv[swik_pkg::ST_PREP + s]) begin
               chain_ff[s][j] <= step_in;
            end
         end
      end
   end

   // Output stage: finish all wheels into the result register
   swik_pkg::swik_result_type res_in [NW];
   swik_pkg::swik_rsp_type    rsp_in;
   swik_pkg::swik_rsp_type    rsp_ff;

   always_comb begin
      for (int j = 0; j < NW; j++) begin
         res_in[j] = swik_pkg::wheel_finish(chain_ff[swik_pkg::RT_STEPS][j]);
      end
      rsp_in.front_right_angle = res_in[0].angle;
      rsp_in.front_right_speed = res_in[0].speed;
      rsp_in.front_left_angle  = res_in[1].angle;
      rsp_in.front_left_speed  = res_in[1].speed;
      rsp_in.mid_right_angle   = res_in[2].angle;
      rsp_in.mid_right_speed   = res_in[2].speed;
      rsp_in.mid_left_angle    = res_in[3].angle;
      rsp_in.mid_left_speed    = res_in[3].speed;
      rsp_in.rear_right_angle  = res_in[4].angle;
      rsp_in.rear_right_speed  = res_in[4].speed;
      rsp_in.rear_left_angle   = res_in[5].angle;
      rsp_in.rear_left_speed   = res_in[5].speed;
   end

   always_ff @(posedge clock) begin
      if (adv[swik_pkg::ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* src/swik_checker.sv */
// Port-level checks for the six wheel steering block, bound to the top.
// Depends on swik_pkg and the assertion macro header.
`include "six_wheel_steering_inverse_kinematics_assert.svh"

module swik_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input swik_pkg::swik_rsp_type rsp_payload
);

   // Hold a stalled result
   `SWIK_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // Drop all results on reset
   `SWIK_ASSERT_NXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // Mid wheels share the lateral component, so their angle signs agree
   `SWIK_ASSERT_IMP(a_mid_sign, clock, reset, rsp_valid && !rsp_payload.mid_right_angle[15] && (rsp_payload.mid_right_angle != 16'sd0), !rsp_payload.mid_left_angle[15] || (rsp_payload.mid_left_angle == 16'sh8000), "mid wheel angle signs disagree")

   // Front wheels share the lateral component as well
   `SWIK_ASSERT_IMP(a_front_sign, clock, reset, rsp_valid && !rsp_payload.front_right_angle[15] && (rsp_payload.front_right_angle != 16'sd0), !rsp_payload.front_left_angle[15] || (rsp_payload.front_left_angle == 16'sh8000), "front wheel angle signs disagree")

endmodule

bind six_wheel_steering_inverse_kinematics swik_checker u_swik_checker (.*);

/* bench/testbench.sv */
// Testbench for the six wheel steering inverse kinematics block.
// Predicts each wheel angle and speed from the command and the geometry registers,
// checks every response in order. Depends on swik_pkg and the block top level.
`timescale 1ns / 1ps

class steer_scoreboard;
   swik_pkg::swik_rsp_type wheel_queue[$];
   logic [swik_pkg::CFG_W-1:0] half_track;
   logic [swik_pkg::CFG_W-1:0] front_dist;
   logic [swik_pkg::CFG_W-1:0] rear_dist;
   int errors;

   function void set_geometry(swik_pkg::swik_csr_type idx, logic [swik_pkg::CFG_W-1:0] v);
      case (idx)
         swik_pkg::CSR_HALF_TRACK: half_track = v;
         swik_pkg::CSR_FRONT_DIST: front_dist = v;
         swik_pkg::CSR_REAR_DIST: rear_dist = v;
         default: ;
      endcase
   endfunction

   // Floor shift of a signed value
   function longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function longint first_quadrant(longint ax, longint ay);
      longint x, y, z, nx;
      if (ay == 0) return 0;
      if (ax == 0) return swik_pkg::QUARTER;
      x = ax;
      y = ay;
      z = 0;
      while (x < (64'sd1 << swik_pkg::NORM_EXP) && y < (64'sd1 << swik_pkg::NORM_EXP)) begin
         x *= 2;
         y *= 2;
      end
      for (int i = 0; i < swik_pkg::CORDIC_STEPS; i++) begin
         if (y >= 0) begin
            nx = x + fshift(y, i);
            y = y - fshift(x, i);
            z += swik_pkg::ATAN_TAB[i];
         end else begin
            nx = x - fshift(y, i);
            y = y + fshift(x, i);
            z -= swik_pkg::ATAN_TAB[i];
         end
         x = nx;
      end
      if (z < 0) z = 0;
      if (z > swik_pkg::Z_MAX) z = swik_pkg::Z_MAX;
      return (z + swik_pkg::Z_RND) >> swik_pkg::Z_SHIFT;
   endfunction

   function void wheel_motion(longint ux, longint uy,
                              output logic [swik_pkg::ANG_W-1:0] ang,
                              output logic [swik_pkg::SPD_W-1:0] spd);
      longint unsigned mx, my, s;
      longint a;
      mx = ux < 0 ? -ux : ux;
      my = uy < 0 ? -uy : uy;
      if (mx == 0 && my == 0) begin
         ang = '0;
         spd = '0;
         return;
      end
      s = (int_sqrt(mx * mx + my * my) + swik_pkg::SPEED_HALF) >> swik_pkg::FRAC_BITS;
      if (s > swik_pkg::SPEED_MAX) s = swik_pkg::SPEED_MAX;
      a = first_quadrant(mx, my);
      if (ux < 0) a = swik_pkg::HALF_TURN - a;
      if (uy < 0) a = -a;
      ang = a[swik_pkg::ANG_W-1:0];
      spd = s[swik_pkg::SPD_W-1:0];
   endfunction

   // Note an accepted request: work out all six wheels
   function void note_request(swik_pkg::swik_req_type r);
      longint vx, vy, w, yt, fx, rx;
      swik_pkg::swik_rsp_type e;
      vx = longint'(r.lin_x) * (1 << swik_pkg::FRAC_BITS);
      vy = longint'(r.lin_y) * (1 << swik_pkg::FRAC_BITS);
      w = longint'(r.yaw_rate);
      yt = half_track;
      fx = front_dist;
      rx = -longint'(rear_dist);
      wheel_motion(vx + w * yt, vy + w * fx, e.front_right_angle, e.front_right_speed);
      wheel_motion(vx - w * yt, vy + w * fx, e.front_left_angle, e.front_left_speed);
      wheel_motion(vx + w * yt, vy, e.mid_right_angle, e.mid_right_speed);
      wheel_motion(vx - w * yt, vy, e.mid_left_angle, e.mid_left_speed);
      wheel_motion(vx + w * yt, vy + w * rx, e.rear_right_angle, e.rear_right_speed);
      wheel_motion(vx - w * yt, vy + w * rx, e.rear_left_angle, e.rear_left_speed);
      wheel_queue.push_back(e);
   endfunction

   function void cmp(string name, longint e, longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         errors++;
      end
   endfunction

   // Check one accepted response against the oldest expectation
   function void check_response(swik_pkg::swik_rsp_type a);
      swik_pkg::swik_rsp_type e;
      if (wheel_queue.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      e = wheel_queue.pop_front();
      cmp("front_right_angle", e.front_right_angle, a.front_right_angle);
      cmp("front_right_speed", e.front_right_speed, a.front_right_speed);
      cmp("front_left_angle", e.front_left_angle, a.front_left_angle);
      cmp("front_left_speed", e.front_left_speed, a.front_left_speed);
      cmp("mid_right_angle", e.mid_right_angle, a.mid_right_angle);
      cmp("mid_right_speed", e.mid_right_speed, a.mid_right_speed);
      cmp("mid_left_angle", e.mid_left_angle, a.mid_left_angle);
      cmp("mid_left_speed", e.mid_left_speed, a.mid_left_speed);
      cmp("rear_right_angle", e.rear_right_angle, a.rear_right_angle);
      cmp("rear_right_speed", e.rear_right_speed, a.rear_right_speed);
      cmp("rear_left_angle", e.rear_left_angle, a.rear_left_angle);
      cmp("rear_left_speed", e.rear_left_speed, a.rear_left_speed);
   endfunction
endclass

module testbench;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   swik_pkg::swik_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   swik_pkg::swik_rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [swik_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [swik_pkg::CFG_W-1:0] csr_wdata = '0;

   steer_scoreboard board;
   int cycles = 0;
   int limit = 400000;
   bit stall_quiet = 1'b0;

   six_wheel_steering_inverse_kinematics u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Check responses and advance the cycle counter
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_payload);
      if (cycles > limit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver stalls at random, with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (stall_quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
      end
   end

   always begin
      repeat ($urandom_range(50, 300)) @(posedge clock);
      stall_quiet = ~stall_quiet;
   end

   // Write one register, then deassert the write enable before returning
   task automatic write_geometry(swik_pkg::swik_csr_type idx,
                                 logic [swik_pkg::CFG_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.set_geometry(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(logic [15:0] x, logic [15:0] y, logic [15:0] w);
      swik_pkg::swik_req_type r;
      int g;
      r.lin_x = x;
      r.lin_y = y;
      r.yaw_rate = w;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic finish_requests();
      req_valid <= 1'b0;
      while (board.wheel_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [15:0] x, y, w;
      for (int i = 0; i < n; i++) begin
         x = 16'($urandom);
         y = 16'($urandom);
         w = 16'($urandom);
         // Zero some fields to hit the axis cases
         case ($urandom_range(0, 7))
            0: y = '0;
            1: x = '0;
            2: w = '0;
            3: begin x = '0; y = '0; end
            default: ;
         endcase
         send_request(x, y, w);
      end
      finish_requests();
   endtask

   initial begin
      logic [15:0] edges[5];
      board = new();
      board.half_track = swik_pkg::HALF_TRACK_RST;
      board.front_dist = swik_pkg::FRONT_DIST_RST;
      board.rear_dist = swik_pkg::REAR_DIST_RST;
      edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, axis and zero cases at reset geometry
      send_request(16'd0, 16'd0, 16'd0);
      send_request(16'd100, 16'd0, 16'd0);
      send_request(16'hff9c, 16'd0, 16'd0);
      send_request(16'd0, 16'd100, 16'd0);
      send_request(16'd0, 16'hff9c, 16'd0);
      for (int i = 0; i < 5; i++) send_request(edges[i], edges[(i + 2) % 5], edges[(i + 4) % 5]);
      send_request(16'h8000, 16'h8000, 16'h8000);
      send_request(16'h7fff, 16'h7fff, 16'h7fff);
      send_request(16'h0000, 16'h0000, 16'h7fff);
      send_request(16'h0200, 16'h0000, 16'h0400);
      finish_requests();

      // Geometry settings including the extremes
      random_phase(110);
      write_geometry(swik_pkg::CSR_HALF_TRACK, 13'h1fff);
      write_geometry(swik_pkg::CSR_FRONT_DIST, 13'h1fff);
      write_geometry(swik_pkg::CSR_REAR_DIST, 13'h1fff);
      send_request(16'h8000, 16'h7fff, 16'h8000);
      send_request(16'h7fff, 16'h8000, 16'h7fff);
      random_phase(110);
      write_geometry(swik_pkg::CSR_HALF_TRACK, 13'd0);
      write_geometry(swik_pkg::CSR_FRONT_DIST, 13'd0);
      write_geometry(swik_pkg::CSR_REAR_DIST, 13'd0);
      random_phase(60);
      write_geometry(swik_pkg::CSR_HALF_TRACK, swik_pkg::CFG_W'($urandom));
      write_geometry(swik_pkg::CSR_FRONT_DIST, swik_pkg::CFG_W'($urandom));
      write_geometry(swik_pkg::CSR_REAR_DIST, swik_pkg::CFG_W'($urandom));
      random_phase(150);

      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+src
src/swik_pkg.sv
src/six_wheel_steering_inverse_kinematics.sv
src/swik_checker.sv
bench/testbench.sv
